// ===== sv/u2u_pkg.sv =====
`timescale 1ns / 1ps

package u2u_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_MARK = 1'b1;

  localparam logic [15:0] BOM_UNIT = 16'hFEFF;
  localparam logic [7:0] SIG_LEAD = 8'hEF;
  localparam logic [7:0] SIG_CONT1 = 8'hBB;
  localparam logic [7:0] SIG_CONT2 = 8'hBF;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       is_error;
  } res_t;

endpackage

// ===== sv/u2u_if.sv =====
`timescale 1ns / 1ps

interface u2u_byte_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink (input valid, input kind, input in_byte, output ready);
endinterface

interface u2u_unit_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic       is_error;

  modport source (output valid, output first_byte, output second_byte, output is_error,
                  input ready);
  modport sink (input valid, input first_byte, input second_byte, input is_error,
                output ready);
endinterface

// ===== sv/u2u_in_stage.sv =====
`timescale 1ns / 1ps

module u2u_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  u2u_pkg::item_t in_item,
  input  logic           pop,
  output logic           item_valid,
  output u2u_pkg::item_t item
);
  import u2u_pkg::*;

  logic  valid_r;
  item_t item_r;

  assign in_ready   = !valid_r || pop;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (pop) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

// ===== sv/u2u_core.sv =====
`timescale 1ns / 1ps

module u2u_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  u2u_pkg::item_t item,
  input  logic           big_endian,
  input  logic           write_mark,
  output logic           res_emit,
  output u2u_pkg::res_t  res
);
  import u2u_pkg::*;

  logic [7:0] three_lead_r, three_lead_nxt;
  logic [7:0] pair_r, pair_nxt;
  logic [7:0] first_cont_r, first_cont_nxt;
  logic       mark_pend_r, mark_pend_nxt;

  logic        held_tl, held_pair, held_fc;
  logic        chk;
  logic        err;
  logic [15:0] unit;
  logic [7:0]  b;

  always_comb begin
    b              = item.in_byte;
    held_tl        = (three_lead_r != 8'h00);
    held_pair      = (pair_r != 8'h00);
    held_fc        = (first_cont_r != 8'h00);
    three_lead_nxt = three_lead_r;
    pair_nxt       = pair_r;
    first_cont_nxt = first_cont_r;
    mark_pend_nxt  = mark_pend_r;
    res_emit       = 1'b0;
    err            = 1'b0;
    chk            = 1'b0;
    unit           = 16'h0000;

    if (item.kind) begin
      three_lead_nxt = 8'h00;
      pair_nxt       = 8'h00;
      first_cont_nxt = 8'h00;
      mark_pend_nxt  = 1'b1;
      res_emit       = write_mark;
      unit           = BOM_UNIT;
    end else begin
      case (b) inside
        [8'h00:8'h7F]: begin
          if (held_tl || held_pair || held_fc) begin
            err = 1'b1;
          end else begin
            res_emit = 1'b1;
            unit     = {8'h00, b};
          end
        end
        [8'hE0:8'hEF]: begin
          if (held_fc || held_pair || held_tl) begin
            err = 1'b1;
          end else begin
            three_lead_nxt = b;
            chk            = 1'b1;
          end
        end
        [8'hC0:8'hDF]: begin
          if (held_fc || held_pair) begin
            err = 1'b1;
          end else begin
            pair_nxt = b;
            chk      = 1'b1;
          end
        end
        [8'h80:8'hBF]: begin
          if (!held_fc) begin
            first_cont_nxt = b;
            chk            = 1'b1;
          end else if (!held_pair && held_tl) begin
            pair_nxt = b;
            chk      = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        default: begin
        end
      endcase

      if (chk && (first_cont_nxt != 8'h00) && (pair_nxt != 8'h00)) begin
        if (three_lead_nxt == 8'h00) begin
          res_emit = 1'b1;
          unit     = {5'b00000, pair_nxt[4:0], first_cont_nxt[5:0]};
        end else if (mark_pend_r && three_lead_nxt == SIG_LEAD &&
                     first_cont_nxt == SIG_CONT1 && pair_nxt == SIG_CONT2) begin
          mark_pend_nxt = 1'b0;
        end else begin
          mark_pend_nxt = 1'b0;
          res_emit      = 1'b1;
          unit          = {three_lead_nxt[3:0], first_cont_nxt[5:0], pair_nxt[5:0]};
        end
        three_lead_nxt = 8'h00;
        pair_nxt       = 8'h00;
        first_cont_nxt = 8'h00;
      end

      if (err) begin
        three_lead_nxt = 8'h00;
        pair_nxt       = 8'h00;
        first_cont_nxt = 8'h00;
        res_emit       = 1'b1;
        unit           = 16'h0000;
      end
    end

    res.is_error    = err;
    res.first_byte  = big_endian ? unit[15:8] : unit[7:0];
    res.second_byte = big_endian ? unit[7:0] : unit[15:8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      three_lead_r <= 8'h00;
      pair_r       <= 8'h00;
      first_cont_r <= 8'h00;
      mark_pend_r  <= 1'b1;
    end else if (adv) begin
      three_lead_r <= three_lead_nxt;
      pair_r       <= pair_nxt;
      first_cont_r <= first_cont_nxt;
      mark_pend_r  <= mark_pend_nxt;
    end
  end

  a_err_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_emit && res.is_error |=>
      three_lead_r == 8'h00 && pair_r == 8'h00 && first_cont_r == 8'h00)
    else $error("held bytes not cleared after sequence fault");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_emit && res.is_error |-> res.first_byte == 8'h00 && res.second_byte == 8'h00)
    else $error("error result carries data");

  a_start_sets_mark: assert property (@(posedge clk) disable iff (!rst_n)
    adv && item.kind |=> mark_pend_r && three_lead_r == 8'h00)
    else $error("start request did not reset decoder");

  a_mark_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(mark_pend_r) |-> $past(adv && item.kind))
    else $error("mark check rearmed without start request");

endmodule

// ===== sv/u2u_out_stage.sv =====
`timescale 1ns / 1ps

module u2u_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  u2u_pkg::res_t res,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output u2u_pkg::res_t out_res
);
  import u2u_pkg::*;

  logic valid_r;
  res_t res_r;

  assign space     = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// ===== sv/utf8_to_utf16_converter.sv =====
`timescale 1ns / 1ps
// An input request reaches the result through two registers: the input register, then the result register.
// Throughput: one byte per cycle, sustained while the result side keeps up.
// Bytes that complete no unit leave the input register without a result.
// Synchronous active-low reset clears decoder state, both registers' valid flags,
// sets the leading-mark check and sets big_endian and write_mark to 0.

module utf8_to_utf16_converter (
  input  logic                           clk,
  input  logic                           rst_n,
  u2u_byte_if.sink                       in_ch,
  u2u_unit_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [u2u_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [u2u_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import u2u_pkg::*;

  logic  big_endian_r;
  logic  write_mark_r;
  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  adv;
  logic  space;
  logic  res_emit;
  res_t  res;
  res_t  out_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
      write_mark_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIG_ENDIAN: big_endian_r <= cfg_wdata[0];
        CFG_WRITE_MARK: write_mark_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign in_item.kind    = in_ch.kind;
  assign in_item.in_byte = in_ch.in_byte;
  assign adv             = item_valid && space;

  u2u_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_item    (in_item),
    .pop        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  u2u_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .item       (item),
    .big_endian (big_endian_r),
    .write_mark (write_mark_r),
    .res_emit   (res_emit),
    .res        (res)
  );

  u2u_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (adv && res_emit),
    .res       (res),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.first_byte  = out_res.first_byte;
  assign out_ch.second_byte = out_res.second_byte;
  assign out_ch.is_error    = out_res.is_error;

endmodule
